FILE: rtl/core/stereo_nested_allpass_diffuser_core_assert.svh
// Assertion macros for the stereo nested allpass diffuser core.
// Each macro places one labeled concurrent assertion on a given clock and disable.
`ifndef STEREO_NESTED_ALLPASS_DIFFUSER_CORE_ASSERT_SVH
`define STEREO_NESTED_ALLPASS_DIFFUSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SNAD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("snad: property violated");

// Next-cycle implication.
`define SNAD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("snad: property violated");

`endif

FILE: rtl/core/snad_pkg.sv
// Shared types, constants and helper functions of the nested allpass diffuser.
// Used by snad_lane, snad_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps

package snad_pkg;

  localparam int OUTER_LINE_DEPTH  = 2048;
  localparam int MIDDLE_LINE_DEPTH = 1024;
  localparam int INNER_LINE_DEPTH  = 512;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int MULT_W   = PROD_W - 15;
  localparam int SUM_W    = SAMPLE_W + 2;

  localparam int OUTER_DELAY_W  = 11;
  localparam int MIDDLE_DELAY_W = 10;
  localparam int INNER_DELAY_W  = 9;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [OUTER_DELAY_W-1:0]  OUTER_DELAY_RST  = 11'd1024;
  localparam logic [MIDDLE_DELAY_W-1:0] MIDDLE_DELAY_RST = 10'd359;
  localparam logic [INNER_DELAY_W-1:0]  INNER_DELAY_RST  = 9'd127;
  localparam logic signed [GAIN_W-1:0]  GAIN_RST         = 16'sd6554;

  localparam logic signed [PROD_W-1:0]  ROUND_HALF = 40'sd16384;

  localparam logic [2:0] LAST_STEP = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_DELAY     = 3'd0,
    REG_MIDDLE_DELAY    = 3'd1,
    REG_INNER_DELAY     = 3'd2,
    REG_OUTER_GAIN      = 3'd3,
    REG_MIDDLE_GAIN     = 3'd4,
    REG_INNER_GAIN      = 3'd5,
    REG_OUTER_PRE_NEST  = 3'd6,
    REG_MIDDLE_PRE_NEST = 3'd7
  } cfg_reg_t;

  // A: v = x - g*d, B: y = d + g*v
  typedef enum logic [2:0] {
    OP_INNER_A,
    OP_INNER_B,
    OP_MIDDLE_A,
    OP_MIDDLE_B,
    OP_OUTER_A,
    OP_OUTER_B
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ADD,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic load;
    logic mul;
    logic add;
    logic wr_outer;
    logic wr_middle;
    logic wr_inner;
    logic clr;
    op_t  op;
  } lane_ctrl_t;

  // Order of the six multiply/add steps for the nesting mode.
  function automatic op_t op_at(input logic [2:0] step, input logic opre,
                                input logic mpre);
    logic [2:0] k;
    op_t mid;
    op_t r;
    k = opre ? (step - 3'd1) : step;
    case (k[1:0])
      2'd0:    mid = mpre ? OP_MIDDLE_A : OP_INNER_A;
      2'd1:    mid = mpre ? OP_INNER_A  : OP_INNER_B;
      2'd2:    mid = mpre ? OP_INNER_B  : OP_MIDDLE_A;
      default: mid = OP_MIDDLE_B;
    endcase
    if (step == LAST_STEP) begin
      r = OP_OUTER_B;
    end else if (opre) begin
      r = (step == 3'd0) ? OP_OUTER_A : mid;
    end else begin
      r = (step == (LAST_STEP - 3'd1)) ? OP_OUTER_A : mid;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (!v[SUM_W-1] && (v[SUM_W-2] || v[SUM_W-3])) begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (v[SUM_W-1] && !(v[SUM_W-2] && v[SUM_W-3])) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/snad_lane.sv
// One channel of the diffuser: three delay-line memories, level registers and
// one shared multiplier stepped by the controller. Depends on snad_pkg.
`timescale 1ns / 1ps

module snad_lane #(
  parameter int OUTER_LINE_DEPTH  = snad_pkg::OUTER_LINE_DEPTH,
  parameter int MIDDLE_LINE_DEPTH = snad_pkg::MIDDLE_LINE_DEPTH,
  parameter int INNER_LINE_DEPTH  = snad_pkg::INNER_LINE_DEPTH,
  localparam int OAW = $clog2(OUTER_LINE_DEPTH),
  localparam int MAW = $clog2(MIDDLE_LINE_DEPTH),
  localparam int IAW = $clog2(INNER_LINE_DEPTH)
) (
  input  logic                                       clk,
  input  snad_pkg::lane_ctrl_t                       ctrl,
  input  logic [OAW-1:0]                             outer_raddr,
  input  logic [MAW-1:0]                             middle_raddr,
  input  logic [IAW-1:0]                             inner_raddr,
  input  logic [OAW-1:0]                             outer_waddr,
  input  logic [MAW-1:0]                             middle_waddr,
  input  logic [IAW-1:0]                             inner_waddr,
  input  logic signed [snad_pkg::GAIN_W-1:0]         outer_gain,
  input  logic signed [snad_pkg::GAIN_W-1:0]         middle_gain,
  input  logic signed [snad_pkg::GAIN_W-1:0]         inner_gain,
  input  logic                                       outer_pre_nest,
  input  logic                                       middle_pre_nest,
  input  logic signed [snad_pkg::SAMPLE_W-1:0]       dry,
  output logic signed [snad_pkg::SAMPLE_W-1:0]       wet
);

  logic signed [snad_pkg::SAMPLE_W-1:0] outer_mem  [OUTER_LINE_DEPTH];
  logic signed [snad_pkg::SAMPLE_W-1:0] middle_mem [MIDDLE_LINE_DEPTH];
  logic signed [snad_pkg::SAMPLE_W-1:0] inner_mem  [INNER_LINE_DEPTH];

  logic signed [snad_pkg::SAMPLE_W-1:0] outer_rdata, middle_rdata, inner_rdata;
  logic signed [snad_pkg::SAMPLE_W-1:0] x_o, d_o, v_o, d_m, v_m, d_i, v_i;

  logic signed [snad_pkg::SAMPLE_W-1:0] mul_a;
  logic signed [snad_pkg::GAIN_W-1:0]   mul_g;
  logic signed [snad_pkg::PROD_W-1:0]   prod;
  logic signed [snad_pkg::MULT_W-1:0]   mult;
  logic signed [snad_pkg::SAMPLE_W-1:0] base;
  logic                                 is_b;
  logic signed [snad_pkg::SUM_W-1:0]    sum;
  logic signed [snad_pkg::SAMPLE_W-1:0] res;

  // Delay-line memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      outer_rdata  <= outer_mem[outer_raddr];
      middle_rdata <= middle_mem[middle_raddr];
      inner_rdata  <= inner_mem[inner_raddr];
    end
    if (ctrl.wr_outer) begin
      outer_mem[outer_waddr] <= ctrl.clr ? '0 : v_o;
    end
    if (ctrl.wr_middle) begin
      middle_mem[middle_waddr] <= ctrl.clr ? '0 : v_m;
    end
    if (ctrl.wr_inner) begin
      inner_mem[inner_waddr] <= ctrl.clr ? '0 : v_i;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_g = '0;
    base  = '0;
    is_b  = 1'b0;
    unique case (ctrl.op)
      snad_pkg::OP_INNER_A: begin
        mul_a = d_i;
        mul_g = inner_gain;
        base  = middle_pre_nest ? v_m : d_m;
      end
      snad_pkg::OP_INNER_B: begin
        mul_a = v_i;
        mul_g = inner_gain;
        base  = d_i;
        is_b  = 1'b1;
      end
      snad_pkg::OP_MIDDLE_A: begin
        mul_a = d_m;
        mul_g = middle_gain;
        base  = outer_pre_nest ? v_o : d_o;
      end
      snad_pkg::OP_MIDDLE_B: begin
        mul_a = v_m;
        mul_g = middle_gain;
        base  = d_m;
        is_b  = 1'b1;
      end
      snad_pkg::OP_OUTER_A: begin
        mul_a = d_o;
        mul_g = outer_gain;
        base  = x_o;
      end
      snad_pkg::OP_OUTER_B: begin
        mul_a = v_o;
        mul_g = outer_gain;
        base  = d_o;
        is_b  = 1'b1;
      end
      default: begin
        mul_a = '0;
        mul_g = '0;
      end
    endcase
  end

  // Round to Q1.23: add half an LSB, then floor by the arithmetic shift
  assign prod = mul_a * mul_g + snad_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      mult <= prod[snad_pkg::PROD_W-1:15];
    end
  end

  always_comb begin
    if (is_b) begin
      sum = snad_pkg::SUM_W'(base) + snad_pkg::SUM_W'(mult);
    end else begin
      sum = snad_pkg::SUM_W'(base) - snad_pkg::SUM_W'(mult);
    end
    res = snad_pkg::sat24(sum);
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      x_o <= dry;
    end
    if (ctrl.load) begin
      d_o <= outer_rdata;
      d_m <= middle_rdata;
      d_i <= inner_rdata;
    end
    if (ctrl.add) begin
      unique case (ctrl.op)
        snad_pkg::OP_INNER_A:  v_i <= res;
        snad_pkg::OP_INNER_B: begin
          // inner result replaces whatever the middle level fed it
          if (middle_pre_nest) begin
            v_m <= res;
          end else begin
            d_m <= res;
          end
        end
        snad_pkg::OP_MIDDLE_A: v_m <= res;
        snad_pkg::OP_MIDDLE_B: begin
          if (outer_pre_nest) begin
            v_o <= res;
          end else begin
            d_o <= res;
          end
        end
        snad_pkg::OP_OUTER_A:  v_o <= res;
        snad_pkg::OP_OUTER_B:  wet <= res;
        default:               wet <= wet;
      endcase
    end
  end

endmodule

FILE: rtl/core/snad_ctrl.sv
// Sequencer shared by both lanes: clearing pass, step order, delay-line
// read/write positions and the item handshake. Depends on snad_pkg.
`timescale 1ns / 1ps

module snad_ctrl #(
  parameter int OUTER_LINE_DEPTH  = snad_pkg::OUTER_LINE_DEPTH,
  parameter int MIDDLE_LINE_DEPTH = snad_pkg::MIDDLE_LINE_DEPTH,
  parameter int INNER_LINE_DEPTH  = snad_pkg::INNER_LINE_DEPTH,
  localparam int OAW = $clog2(OUTER_LINE_DEPTH),
  localparam int MAW = $clog2(MIDDLE_LINE_DEPTH),
  localparam int IAW = $clog2(INNER_LINE_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                slot_free,
  input  logic [snad_pkg::OUTER_DELAY_W-1:0]  outer_delay,
  input  logic [snad_pkg::MIDDLE_DELAY_W-1:0] middle_delay,
  input  logic [snad_pkg::INNER_DELAY_W-1:0]  inner_delay,
  input  logic                                outer_pre_nest,
  input  logic                                middle_pre_nest,
  output logic                                busy,
  output logic                                out_load,
  output snad_pkg::lane_ctrl_t                ctrl,
  output logic [OAW-1:0]                      outer_raddr,
  output logic [MAW-1:0]                      middle_raddr,
  output logic [IAW-1:0]                      inner_raddr,
  output logic [OAW-1:0]                      outer_waddr,
  output logic [MAW-1:0]                      middle_waddr,
  output logic [IAW-1:0]                      inner_waddr
);

  localparam int CLR_DEPTH =
    (OUTER_LINE_DEPTH > MIDDLE_LINE_DEPTH)
      ? ((OUTER_LINE_DEPTH > INNER_LINE_DEPTH) ? OUTER_LINE_DEPTH : INNER_LINE_DEPTH)
      : ((MIDDLE_LINE_DEPTH > INNER_LINE_DEPTH) ? MIDDLE_LINE_DEPTH : INNER_LINE_DEPTH);
  localparam int CW = $clog2(CLR_DEPTH);

  snad_pkg::state_t state, state_next;
  logic [2:0]     step;
  logic [CW-1:0]  clr_cnt;
  logic [OAW-1:0] pos_o, eff_o;
  logic [MAW-1:0] pos_m, eff_m;
  logic [IAW-1:0] pos_i, eff_i;
  logic [31:0]    ext_o, ext_m, ext_i;
  logic           clr_o, clr_m, clr_i;

  // Effective delays: register value clamped to depth-1
  always_comb begin
    ext_o = 32'(outer_delay);
    ext_m = 32'(middle_delay);
    ext_i = 32'(inner_delay);
    eff_o = (ext_o < 32'(OUTER_LINE_DEPTH))  ? ext_o[OAW-1:0] : OAW'(OUTER_LINE_DEPTH - 1);
    eff_m = (ext_m < 32'(MIDDLE_LINE_DEPTH)) ? ext_m[MAW-1:0] : MAW'(MIDDLE_LINE_DEPTH - 1);
    eff_i = (ext_i < 32'(INNER_LINE_DEPTH))  ? ext_i[IAW-1:0] : IAW'(INNER_LINE_DEPTH - 1);
    clr_o = 32'(clr_cnt) < 32'(OUTER_LINE_DEPTH);
    clr_m = 32'(clr_cnt) < 32'(MIDDLE_LINE_DEPTH);
    clr_i = 32'(clr_cnt) < 32'(INNER_LINE_DEPTH);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snad_pkg::S_CLEAR: begin
        if (clr_cnt == CW'(CLR_DEPTH - 1)) begin
          state_next = snad_pkg::S_IDLE;
        end
      end
      snad_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = snad_pkg::S_LOAD;
        end
      end
      snad_pkg::S_LOAD:  state_next = snad_pkg::S_MUL;
      snad_pkg::S_MUL:   state_next = snad_pkg::S_ADD;
      snad_pkg::S_ADD: begin
        state_next = (step == snad_pkg::LAST_STEP) ? snad_pkg::S_WRITE : snad_pkg::S_MUL;
      end
      snad_pkg::S_WRITE: state_next = snad_pkg::S_DONE;
      snad_pkg::S_DONE: begin
        if (slot_free) begin
          state_next = snad_pkg::S_IDLE;
        end
      end
      default: state_next = snad_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    busy           = (state != snad_pkg::S_IDLE);
    out_load       = (state == snad_pkg::S_DONE) && slot_free;
    ctrl.rd        = (state == snad_pkg::S_IDLE) && in_valid;
    ctrl.load      = (state == snad_pkg::S_LOAD);
    ctrl.mul       = (state == snad_pkg::S_MUL);
    ctrl.add       = (state == snad_pkg::S_ADD);
    ctrl.clr       = (state == snad_pkg::S_CLEAR);
    ctrl.op        = snad_pkg::op_at(step, outer_pre_nest, middle_pre_nest);
    ctrl.wr_outer  = ctrl.clr ? clr_o : (state == snad_pkg::S_WRITE);
    ctrl.wr_middle = ctrl.clr ? clr_m : (state == snad_pkg::S_WRITE);
    ctrl.wr_inner  = ctrl.clr ? clr_i : (state == snad_pkg::S_WRITE);
    outer_raddr    = pos_o;
    middle_raddr   = pos_m;
    inner_raddr    = pos_i;
    if (ctrl.clr) begin
      outer_waddr  = clr_cnt[OAW-1:0];
      middle_waddr = clr_cnt[MAW-1:0];
      inner_waddr  = clr_cnt[IAW-1:0];
    end else begin
      // write one entry behind the read position, wrapping to the delay
      outer_waddr  = (pos_o == '0) ? eff_o : pos_o - 1'b1;
      middle_waddr = (pos_m == '0) ? eff_m : pos_m - 1'b1;
      inner_waddr  = (pos_i == '0) ? eff_i : pos_i - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= snad_pkg::S_CLEAR;
      step    <= '0;
      clr_cnt <= '0;
      pos_o   <= '0;
      pos_m   <= '0;
      pos_i   <= '0;
    end else begin
      state <= state_next;
      if (state == snad_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == snad_pkg::S_LOAD) begin
        step <= '0;
      end else if (state == snad_pkg::S_ADD) begin
        step <= step + 3'd1;
      end
      if (state == snad_pkg::S_WRITE) begin
        pos_o <= (pos_o >= eff_o) ? '0 : pos_o + 1'b1;
        pos_m <= (pos_m >= eff_m) ? '0 : pos_m + 1'b1;
        pos_i <= (pos_i >= eff_i) ? '0 : pos_i + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/stereo_nested_allpass_diffuser_core.sv
// Stereo nested allpass diffuser: left and right lanes share one sequencer.
// An item is accepted in idle and runs the load, multiply, add, write and done
// states; no new item is taken until its result is in the output register,
// which a stalled receiver holds off. Each lane runs the six dependent multiply
// and add steps through its one multiplier. Reset (rst, synchronous) restores
// the register defaults and clears every line entry with in_stall held high.
`timescale 1ns / 1ps

module stereo_nested_allpass_diffuser_core #(
  parameter int OUTER_LINE_DEPTH  = snad_pkg::OUTER_LINE_DEPTH,
  parameter int MIDDLE_LINE_DEPTH = snad_pkg::MIDDLE_LINE_DEPTH,
  parameter int INNER_LINE_DEPTH  = snad_pkg::INNER_LINE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [snad_pkg::SAMPLE_W-1:0]  left_in,
  input  logic signed [snad_pkg::SAMPLE_W-1:0]  right_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [snad_pkg::SAMPLE_W-1:0]  left_out,
  output logic signed [snad_pkg::SAMPLE_W-1:0]  right_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [snad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [snad_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int OAW = $clog2(OUTER_LINE_DEPTH);
  localparam int MAW = $clog2(MIDDLE_LINE_DEPTH);
  localparam int IAW = $clog2(INNER_LINE_DEPTH);

  logic [snad_pkg::OUTER_DELAY_W-1:0]  outer_delay;
  logic [snad_pkg::MIDDLE_DELAY_W-1:0] middle_delay;
  logic [snad_pkg::INNER_DELAY_W-1:0]  inner_delay;
  logic signed [snad_pkg::GAIN_W-1:0]  outer_gain, middle_gain, inner_gain;
  logic                                outer_pre_nest, middle_pre_nest;

  snad_pkg::lane_ctrl_t                ctrl;
  logic                                out_load;
  logic                                slot_free;
  logic [OAW-1:0]                      outer_raddr, outer_waddr;
  logic [MAW-1:0]                      middle_raddr, middle_waddr;
  logic [IAW-1:0]                      inner_raddr, inner_waddr;
  logic signed [snad_pkg::SAMPLE_W-1:0] left_wet, right_wet;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_delay     <= snad_pkg::OUTER_DELAY_RST;
      middle_delay    <= snad_pkg::MIDDLE_DELAY_RST;
      inner_delay     <= snad_pkg::INNER_DELAY_RST;
      outer_gain      <= snad_pkg::GAIN_RST;
      middle_gain     <= snad_pkg::GAIN_RST;
      inner_gain      <= snad_pkg::GAIN_RST;
      outer_pre_nest  <= 1'b1;
      middle_pre_nest <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (snad_pkg::cfg_reg_t'(cfg_index))
        snad_pkg::REG_OUTER_DELAY:     outer_delay     <= cfg_data[snad_pkg::OUTER_DELAY_W-1:0];
        snad_pkg::REG_MIDDLE_DELAY:    middle_delay    <= cfg_data[snad_pkg::MIDDLE_DELAY_W-1:0];
        snad_pkg::REG_INNER_DELAY:     inner_delay     <= cfg_data[snad_pkg::INNER_DELAY_W-1:0];
        snad_pkg::REG_OUTER_GAIN:      outer_gain      <= cfg_data;
        snad_pkg::REG_MIDDLE_GAIN:     middle_gain     <= cfg_data;
        snad_pkg::REG_INNER_GAIN:      inner_gain      <= cfg_data;
        snad_pkg::REG_OUTER_PRE_NEST:  outer_pre_nest  <= cfg_data[0];
        snad_pkg::REG_MIDDLE_PRE_NEST: middle_pre_nest <= cfg_data[0];
        default:                       outer_pre_nest  <= outer_pre_nest;
      endcase
    end
  end

  assign slot_free = !out_valid || !out_stall;

  snad_ctrl #(
    .OUTER_LINE_DEPTH  (OUTER_LINE_DEPTH),
    .MIDDLE_LINE_DEPTH (MIDDLE_LINE_DEPTH),
    .INNER_LINE_DEPTH  (INNER_LINE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .slot_free       (slot_free),
    .outer_delay     (outer_delay),
    .middle_delay    (middle_delay),
    .inner_delay     (inner_delay),
    .outer_pre_nest  (outer_pre_nest),
    .middle_pre_nest (middle_pre_nest),
    .busy            (in_stall),
    .out_load        (out_load),
    .ctrl            (ctrl),
    .outer_raddr     (outer_raddr),
    .middle_raddr    (middle_raddr),
    .inner_raddr     (inner_raddr),
    .outer_waddr     (outer_waddr),
    .middle_waddr    (middle_waddr),
    .inner_waddr     (inner_waddr)
  );

  snad_lane #(
    .OUTER_LINE_DEPTH  (OUTER_LINE_DEPTH),
    .MIDDLE_LINE_DEPTH (MIDDLE_LINE_DEPTH),
    .INNER_LINE_DEPTH  (INNER_LINE_DEPTH)
  ) u_left (
    .clk             (clk),
    .ctrl            (ctrl),
    .outer_raddr     (outer_raddr),
    .middle_raddr    (middle_raddr),
    .inner_raddr     (inner_raddr),
    .outer_waddr     (outer_waddr),
    .middle_waddr    (middle_waddr),
    .inner_waddr     (inner_waddr),
    .outer_gain      (outer_gain),
    .middle_gain     (middle_gain),
    .inner_gain      (inner_gain),
    .outer_pre_nest  (outer_pre_nest),
    .middle_pre_nest (middle_pre_nest),
    .dry             (left_in),
    .wet             (left_wet)
  );

  snad_lane #(
    .OUTER_LINE_DEPTH  (OUTER_LINE_DEPTH),
    .MIDDLE_LINE_DEPTH (MIDDLE_LINE_DEPTH),
    .INNER_LINE_DEPTH  (INNER_LINE_DEPTH)
  ) u_right (
    .clk             (clk),
    .ctrl            (ctrl),
    .outer_raddr     (outer_raddr),
    .middle_raddr    (middle_raddr),
    .inner_raddr     (inner_raddr),
    .outer_waddr     (outer_waddr),
    .middle_waddr    (middle_waddr),
    .inner_waddr     (inner_waddr),
    .outer_gain      (outer_gain),
    .middle_gain     (middle_gain),
    .inner_gain      (inner_gain),
    .outer_pre_nest  (outer_pre_nest),
    .middle_pre_nest (middle_pre_nest),
    .dry             (right_in),
    .wet             (right_wet)
  );

  // Output register joins both lanes into one item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= left_wet;
      right_out <= right_wet;
    end
  end

endmodule

FILE: rtl/core/snad_checker.sv
// Port-level checks for the diffuser core, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "stereo_nested_allpass_diffuser_core_assert.svh"

module snad_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] left_out,
  input logic [23:0] right_out
);

  // hold a stalled result
  `SNAD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(left_out) && $stable(right_out))
  // one item at a time: an accept closes the input
  `SNAD_ASSERT_NXT(a_accept_closes, clk, rst, in_valid && !in_stall, in_stall)
  // a new result reopens the input, and was preceded by a busy cycle
  `SNAD_ASSERT_IMP(a_result_reopens, clk, rst, $rose(out_valid), !in_stall && $past(in_stall))
  // reset starts the clearing pass with the input closed and no result
  `SNAD_ASSERT_NXT(a_reset_clears, clk, 1'b0, rst, in_stall && !out_valid)

endmodule

bind stereo_nested_allpass_diffuser_core snad_checker u_snad_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .left_out  (left_out),
  .right_out (right_out)
);

FILE: tb/diffuser_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the stereo nested allpass diffuser: follows register writes, predicts
// each output pair from its own copy of the six delay lines, and compares in order.
// Depends on snad_pkg for widths, register indexes and reset values.

module diffuser_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [snad_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [snad_pkg::SAMPLE_W-1:0] right_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [snad_pkg::SAMPLE_W-1:0] left_out,
  input  logic signed [snad_pkg::SAMPLE_W-1:0] right_out,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [snad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [snad_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   fail_count,
  output int                                   pending_count,
  output int                                   pairs_in,
  output int                                   pairs_out
);
  import snad_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_t;

  // Register copy
  int    outer_dly, middle_dly, inner_dly;
  gain_t outer_g, middle_g, inner_g;
  logic  outer_pre, middle_pre;

  // Delay lines, index 0 left and 1 right; read positions are shared
  sample_t outer_line  [2][OUTER_LINE_DEPTH];
  sample_t middle_line [2][MIDDLE_LINE_DEPTH];
  sample_t inner_line  [2][INNER_LINE_DEPTH];
  int      outer_pos, middle_pos, inner_pos;

  stereo_t expected_pairs [$];
  int      reported;

  function automatic sample_t clip24(longint v);
    if (v > 64'sd8388607) return sample_t'(24'sh7FFFFF);
    if (v < -64'sd8388608) return sample_t'(24'sh800000);
    return sample_t'(v);
  endfunction

  // Q.38 product rounded to Q1.23, ties toward plus infinity
  function automatic longint gain_mul(longint a, longint g);
    return (a * g + 64'sd16384) >>> 15;
  endfunction

  function automatic int wr_slot(int p, int d);
    return (p == 0) ? d : p - 1;
  endfunction

  function automatic int step_pos(int p, int d);
    return (p >= d) ? 0 : p + 1;
  endfunction

  function automatic sample_t inner_stage(int ch, sample_t x);
    sample_t dout;
    sample_t v;
    dout = inner_line[ch][inner_pos];
    v = clip24(longint'(x) - gain_mul(dout, inner_g));
    inner_line[ch][wr_slot(inner_pos, inner_dly)] = v;
    return clip24(longint'(dout) + gain_mul(v, inner_g));
  endfunction

  function automatic sample_t middle_stage(int ch, sample_t x);
    sample_t dout;
    sample_t v;
    dout = middle_line[ch][middle_pos];
    if (!middle_pre) dout = inner_stage(ch, dout);
    v = clip24(longint'(x) - gain_mul(dout, middle_g));
    if (middle_pre) v = inner_stage(ch, v);
    middle_line[ch][wr_slot(middle_pos, middle_dly)] = v;
    return clip24(longint'(dout) + gain_mul(v, middle_g));
  endfunction

  function automatic sample_t outer_stage(int ch, sample_t x);
    sample_t dout;
    sample_t v;
    dout = outer_line[ch][outer_pos];
    if (!outer_pre) dout = middle_stage(ch, dout);
    v = clip24(longint'(x) - gain_mul(dout, outer_g));
    if (outer_pre) v = middle_stage(ch, v);
    outer_line[ch][wr_slot(outer_pos, outer_dly)] = v;
    return clip24(longint'(dout) + gain_mul(v, outer_g));
  endfunction

  function automatic stereo_t diffuse_pair(sample_t l, sample_t r);
    stereo_t res;
    res.left  = outer_stage(0, l);
    res.right = outer_stage(1, r);
    outer_pos  = step_pos(outer_pos, outer_dly);
    middle_pos = step_pos(middle_pos, middle_dly);
    inner_pos  = step_pos(inner_pos, inner_dly);
    return res;
  endfunction

  always @(posedge clk) begin
    stereo_t want;
    if (rst) begin
      outer_dly  = int'(OUTER_DELAY_RST);
      middle_dly = int'(MIDDLE_DELAY_RST);
      inner_dly  = int'(INNER_DELAY_RST);
      outer_g    = GAIN_RST;
      middle_g   = GAIN_RST;
      inner_g    = GAIN_RST;
      outer_pre  = 1'b1;
      middle_pre = 1'b0;
      for (int i = 0; i < OUTER_LINE_DEPTH; i++) begin
        outer_line[0][i] = '0;
        outer_line[1][i] = '0;
      end
      for (int i = 0; i < MIDDLE_LINE_DEPTH; i++) begin
        middle_line[0][i] = '0;
        middle_line[1][i] = '0;
      end
      for (int i = 0; i < INNER_LINE_DEPTH; i++) begin
        inner_line[0][i] = '0;
        inner_line[1][i] = '0;
      end
      outer_pos = 0;
      middle_pos = 0;
      inner_pos = 0;
      expected_pairs.delete();
      fail_count = 0;
      pending_count = 0;
      pairs_in = 0;
      pairs_out = 0;
      reported = 0;
    end else begin
      // Compare before predicting: an item accepted on this edge cannot be out yet
      if (out_valid && !out_stall) begin
        pairs_out++;
        if (expected_pairs.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            $display("unexpected output item: left %0d right %0d", left_out, right_out);
            reported++;
          end
        end else begin
          want = expected_pairs.pop_front();
          if (left_out !== want.left) begin
            fail_count++;
            if (reported < 10) begin
              $display("item %0d left_out: expected %0d, got %0d",
                       pairs_out - 1, want.left, left_out);
              reported++;
            end
          end
          if (right_out !== want.right) begin
            fail_count++;
            if (reported < 10) begin
              $display("item %0d right_out: expected %0d, got %0d",
                       pairs_out - 1, want.right, right_out);
              reported++;
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_OUTER_DELAY:     outer_dly  = int'(cfg_data[OUTER_DELAY_W-1:0]);
          REG_MIDDLE_DELAY:    middle_dly = int'(cfg_data[MIDDLE_DELAY_W-1:0]);
          REG_INNER_DELAY:     inner_dly  = int'(cfg_data[INNER_DELAY_W-1:0]);
          REG_OUTER_GAIN:      outer_g    = gain_t'(cfg_data);
          REG_MIDDLE_GAIN:     middle_g   = gain_t'(cfg_data);
          REG_INNER_GAIN:      inner_g    = gain_t'(cfg_data);
          REG_OUTER_PRE_NEST:  outer_pre  = cfg_data[0];
          REG_MIDDLE_PRE_NEST: middle_pre = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_pairs.push_back(diffuse_pair(left_in, right_in));
        pairs_in++;
      end
      pending_count = expected_pairs.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the diffuser testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on snad_pkg, the diffuser core and diffuser_checker.

module tb_top;
  import snad_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SMAX = 24'sh7FFFFF;
  localparam sample_t SMIN = 24'sh800000;
  localparam int STUCK_LIMIT = 12000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  sample_t                 left_in = '0;
  sample_t                 right_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  sample_t                 left_out;
  sample_t                 right_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int fail_count, pending_count, pairs_in, pairs_out;
  int settings_loaded = 0;
  int stall_left = 0;
  int stuck = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  stereo_nested_allpass_diffuser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_stall(out_stall), .left_out(left_out),
    .right_out(right_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  diffuser_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_stall(out_stall), .left_out(left_out),
    .right_out(right_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .pairs_in(pairs_in), .pairs_out(pairs_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: mostly ready, short stalls often, long ones now and then
  always @(negedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 19);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_steady || r < 12) begin
      out_stall <= 1'b0;
    end else if (r < 18) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(19, 59);
    end
  end

  // Watchdog: give up after a long stretch with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (tx_steady || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3, 4: return sample_t'($signed($urandom_range(0, 8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int pick_delay(int longest);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return longest;
      3: return $urandom_range(1, longest);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic send_pair(sample_t l, sample_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    left_in <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(int od, int md, int id, int og, int mg, int ig,
                              int opre, int mpre);
    write_reg(REG_OUTER_DELAY, od);
    write_reg(REG_MIDDLE_DELAY, md);
    write_reg(REG_INNER_DELAY, id);
    write_reg(REG_OUTER_GAIN, og);
    write_reg(REG_MIDDLE_GAIN, mg);
    write_reg(REG_INNER_GAIN, ig);
    write_reg(REG_OUTER_PRE_NEST, opre);
    write_reg(REG_MIDDLE_PRE_NEST, mpre);
    settings_loaded++;
  endtask

  // Drop valid, let every expected item come out, then give the core a margin
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default values written back explicitly, full-scale steps
    load_setting(1024, 359, 127, 6554, 6554, 6554, 1, 0);
    send_pair(SMAX, SMIN);
    send_pair(SMIN, SMAX);
    send_pair('0, '0);
    send_pair(sample_t'(1), sample_t'(-1));
    send_pair(sample_t'(-1), sample_t'(1));

    // Zero delays at extreme gains, inner level on the middle delay input
    settle();
    load_setting(0, 0, 0, 32767, -32768, 32767, 0, 1);
    send_pair(SMAX, SMAX);
    send_pair(SMAX, SMAX);
    send_pair(SMIN, SMIN);
    send_pair(SMIN, SMAX);
    send_pair('0, '0);

    // Short delays, both levels nested on the delay output
    settle();
    load_setting(3, 2, 1, -32768, 32767, -32768, 0, 0);
    send_pair(SMAX, SMIN);
    send_pair(SMAX, SMIN);
    send_pair(SMAX, SMIN);
    send_pair(SMIN, SMAX);
    send_pair('0, sample_t'(1));

    // Longest delays, both levels nested on the delay input
    settle();
    load_setting(2047, 1023, 511, -6554, 6554, -6554, 1, 1);
    send_pair(SMAX, SMIN);
    send_pair(SMIN, SMAX);
    send_pair(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
    send_pair(sample_t'(24'hAAAAAA), sample_t'(24'h555555));

    // Shrink the delays under positions already past them
    settle();
    load_setting(2, 1, 0, 32767, 32767, 32767, 1, 1);
    send_pair(SMAX, SMAX);
    send_pair(SMIN, SMIN);
    send_pair(SMAX, SMIN);
    send_pair('0, '0);
    send_pair(sample_t'(-1), SMAX);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      load_setting(pick_delay(2047), pick_delay(1023), pick_delay(511),
                   pick_gain(), pick_gain(), pick_gain(),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat (80) send_pair(pick_sample(), pick_sample());
    end

    settle();
    repeat (16) @(negedge clk);
    $display("run covered %0d stereo items and %0d output items under %0d register settings,",
             pairs_in, pairs_out, settings_loaded);
    $display("all four nesting modes, zero and full-length delays, and saturating gains");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d field mismatches or unexpected items", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
